/* src/tbm_pkg.sv */
// Shared types and constants for the tolerance band monitor.
`default_nettype none

package tbm_pkg;

  localparam int unsigned SampleW  = 16;
  localparam int unsigned LimitW   = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TARGET       = 3'd0,
    REG_WARN_LIMIT   = 3'd1,
    REG_FAULT_LIMIT  = 3'd2,
    REG_STARTUP_WAIT = 3'd3,
    REG_PERSIST      = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    LVL_UNKNOWN = 2'd0,
    LVL_NORMAL  = 2'd1,
    LVL_WARNING = 2'd2,
    LVL_FAULT   = 2'd3
  } level_e;

  typedef enum logic [1:0] {
    BAND_NORMAL = 2'd0,
    BAND_WARN   = 2'd1,
    BAND_FAULT  = 2'd2
  } band_e;

  typedef struct packed {
    logic signed [SampleW-1:0] target;
    logic [LimitW-1:0]         warn_limit;
    logic [LimitW-1:0]         fault_limit;
    logic [TimeW-1:0]          startup_wait;
    logic [TimeW-1:0]          persist;
  } cfg_t;

  typedef struct packed {
    band_e             band;
    logic              waiting;
    logic [LimitW-1:0] deviation;
  } check_t;

endpackage

`default_nettype wire

/* src/tbm_if.sv */
// Valid/ready channel interfaces for check inputs and check results.
`default_nettype none

interface tbm_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic [31:0]        now_ms;

  modport source (output valid, output sample, output now_ms, input ready);
  modport sink   (input valid, input sample, input now_ms, output ready);
endinterface

interface tbm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  level;
  logic        warning_event;
  logic        fault_event;
  logic        waiting;
  logic [15:0] deviation;

  modport source (output valid, output level, output warning_event, output fault_event,
                  output waiting, output deviation, input ready);
  modport sink   (input valid, input level, input warning_event, input fault_event,
                  input waiting, input deviation, output ready);
endinterface

`default_nettype wire

/* src/tbm_check.sv */
// Deviation magnitude, startup-wait test and band classification of one sample.
`default_nettype none

module tbm_check (
  input  tbm_pkg::cfg_t                        cfg_i,
  input  logic signed [tbm_pkg::SampleW-1:0]   sample_i,
  input  logic [tbm_pkg::TimeW-1:0]            now_i,
  output tbm_pkg::check_t                      check_o
);
  import tbm_pkg::*;

  logic [SampleW:0]  diff;
  logic [SampleW:0]  mag;
  logic [LimitW-1:0] dev;

  // 17-bit difference never overflows; its magnitude fits in 16 bits
  assign diff = {sample_i[SampleW-1], sample_i} - {cfg_i.target[SampleW-1], cfg_i.target};
  assign mag  = diff[SampleW] ? (~diff + {{SampleW{1'b0}}, 1'b1}) : diff;
  assign dev  = mag[LimitW-1:0];

  always_comb begin
    check_o.deviation = dev;
    check_o.waiting   = (now_i < cfg_i.startup_wait);
    if (dev <= cfg_i.warn_limit) begin
      check_o.band = BAND_NORMAL;
    end else if (dev <= cfg_i.fault_limit) begin
      check_o.band = BAND_WARN;
    end else begin
      check_o.band = BAND_FAULT;
    end
  end

endmodule

`default_nettype wire

/* src/tolerance_band_monitor.sv */
// Top level: two-level limit check with persistence timers on one signal.
//
//   channel | dir | transfer when        | payload
//   in_i    | in  | in_i.valid & ready   | sample, now_ms
//   out_o   | out | out_o.valid & ready  | level, warning_event, fault_event,
//           |     |                      | waiting, deviation
//   cfg     | in  | cfg_we_i             | cfg_idx_i, cfg_wdata_i
//
// One check per cycle sustained while out_o is not stalled; a result passes from the
// input register, through classify/timer update, into the result register.
// Reset clears configuration to zero, level to unknown and both timers.
// A stall on out_o holds the result; an empty input register still takes one more
// check, then in_i.ready drops until the result is taken.
`default_nettype none

module tolerance_band_monitor (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  tbm_in_if.sink                             in_i,
  tbm_out_if.source                          out_o,
  input  logic                               cfg_we_i,
  input  logic [tbm_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [tbm_pkg::CfgDataW-1:0]       cfg_wdata_i
);
  import tbm_pkg::*;

  cfg_t cfg_q;

  logic                      in_valid_q;
  logic signed [SampleW-1:0] sample_q;
  logic [TimeW-1:0]          now_q;

  level_e           level_q, level_d;
  logic             warn_timing_q, warn_timing_d;
  logic             fault_timing_q, fault_timing_d;
  logic [TimeW-1:0] warn_start_q, warn_start_d;
  logic [TimeW-1:0] fault_start_q, fault_start_d;

  logic              out_valid_q;
  level_e            out_level_q;
  logic              out_wev_q, out_fev_q, out_wait_q;
  logic [LimitW-1:0] out_dev_q;

  check_t           chk;
  logic             adv;
  logic             wev, fev;
  logic [TimeW-1:0] warn_elapsed, fault_elapsed;
  logic             warn_hit, fault_hit;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TARGET:       cfg_q.target       <= cfg_wdata_i[SampleW-1:0];
        REG_WARN_LIMIT:   cfg_q.warn_limit   <= cfg_wdata_i[LimitW-1:0];
        REG_FAULT_LIMIT:  cfg_q.fault_limit  <= cfg_wdata_i[LimitW-1:0];
        REG_STARTUP_WAIT: cfg_q.startup_wait <= cfg_wdata_i[TimeW-1:0];
        REG_PERSIST:      cfg_q.persist      <= cfg_wdata_i[TimeW-1:0];
        default: ;
      endcase
    end
  end

  assign adv        = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || adv;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      sample_q <= in_i.sample;
      now_q    <= in_i.now_ms;
    end
  end

  tbm_check u_check (
    .cfg_i    (cfg_q),
    .sample_i (sample_q),
    .now_i    (now_q),
    .check_o  (chk)
  );

  // a timer not yet running starts at now, so its elapsed time is zero
  assign warn_elapsed  = now_q - warn_start_q;
  assign fault_elapsed = now_q - fault_start_q;
  assign warn_hit  = warn_timing_q  ? (warn_elapsed  >= cfg_q.persist) : (cfg_q.persist == '0);
  assign fault_hit = fault_timing_q ? (fault_elapsed >= cfg_q.persist) : (cfg_q.persist == '0);

  always_comb begin
    level_d        = level_q;
    warn_timing_d  = warn_timing_q;
    fault_timing_d = fault_timing_q;
    warn_start_d   = warn_start_q;
    fault_start_d  = fault_start_q;
    wev            = 1'b0;
    fev            = 1'b0;
    if (!chk.waiting) begin
      case (chk.band)
        BAND_NORMAL: begin
          level_d        = LVL_NORMAL;
          warn_timing_d  = 1'b0;
          fault_timing_d = 1'b0;
        end
        BAND_WARN: begin
          fault_timing_d = 1'b0;
          if (!warn_timing_q) begin
            warn_timing_d = 1'b1;
            warn_start_d  = now_q;
          end
          if (warn_hit) begin
            wev     = (level_q != LVL_WARNING);
            level_d = LVL_WARNING;
          end
        end
        BAND_FAULT: begin
          // warning timer left as it is
          if (!fault_timing_q) begin
            fault_timing_d = 1'b1;
            fault_start_d  = now_q;
          end
          if (fault_hit) begin
            fev     = (level_q != LVL_FAULT);
            level_d = LVL_FAULT;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q        <= LVL_UNKNOWN;
      warn_timing_q  <= 1'b0;
      fault_timing_q <= 1'b0;
      warn_start_q   <= '0;
      fault_start_q  <= '0;
    end else if (adv) begin
      level_q        <= level_d;
      warn_timing_q  <= warn_timing_d;
      fault_timing_q <= fault_timing_d;
      warn_start_q   <= warn_start_d;
      fault_start_q  <= fault_start_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_level_q <= level_d;
      out_wev_q   <= wev;
      out_fev_q   <= fev;
      out_wait_q  <= chk.waiting;
      out_dev_q   <= chk.deviation;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.level         = out_level_q;
  assign out_o.warning_event = out_wev_q;
  assign out_o.fault_event   = out_fev_q;
  assign out_o.waiting       = out_wait_q;
  assign out_o.deviation     = out_dev_q;

  // checks
  a_wait_no_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_wait_q |-> !out_wev_q && !out_fev_q)
    else $error("event reported during startup wait");

  a_wev_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_wev_q |-> out_level_q == LVL_WARNING)
    else $error("warning event without warning level");

  a_fev_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_fev_q |-> out_level_q == LVL_FAULT)
    else $error("fault event without fault level");

  a_level_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(adv) |-> $stable(level_q))
    else $error("level changed without a check");

endmodule

`default_nettype wire
